### rtl/core/cpfc_pkg.sv
// Package: shared types, constants and the CRC8 step for the chunk packet framer.
`timescale 1ns / 1ps
`default_nettype none

package cpfc_pkg;

   localparam int ByteW = 8;
   localparam int PosW  = 4;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_SYNC_FIRST    = 3'd0;
   localparam logic [2:0] REG_SYNC_SECOND   = 3'd1;
   localparam logic [2:0] REG_CHUNK_COMMAND = 3'd2;
   localparam logic [2:0] REG_FOOT_MARKER   = 3'd3;
   localparam logic [2:0] REG_END_COMMAND   = 3'd4;

   // Byte positions inside a chunk frame.
   localparam logic [PosW-1:0] POS_SYNC_FIRST  = 4'd0;
   localparam logic [PosW-1:0] POS_SYNC_SECOND = 4'd1;
   localparam logic [PosW-1:0] POS_COMMAND     = 4'd2;
   localparam logic [PosW-1:0] POS_OFFSET_0    = 4'd3;
   localparam logic [PosW-1:0] POS_OFFSET_1    = 4'd4;
   localparam logic [PosW-1:0] POS_OFFSET_2    = 4'd5;
   localparam logic [PosW-1:0] POS_OFFSET_3    = 4'd6;
   localparam logic [PosW-1:0] POS_SIZE_0      = 4'd7;
   localparam logic [PosW-1:0] POS_SIZE_1      = 4'd8;
   localparam logic [PosW-1:0] POS_FOOT        = 4'd9;
   localparam logic [PosW-1:0] POS_HDR_CRC     = 4'd10;
   localparam logic [PosW-1:0] POS_DATA        = 4'd11;
   localparam logic [PosW-1:0] POS_DATA_CRC    = 4'd12;
   localparam logic [PosW-1:0] POS_TERM        = 4'd13;
   // In an end frame the CRC follows the command byte.
   localparam logic [PosW-1:0] POS_END_CRC     = 4'd3;

   localparam logic [ByteW-1:0] CRC_POLY   = 8'h07;
   localparam logic [ByteW-1:0] CRC_MSB    = 8'h80;
   localparam logic [ByteW-1:0] TERMINATOR = 8'hFF;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } cpfc_op_type;

   typedef struct packed {
      logic [ByteW-1:0] sync_first;
      logic [ByteW-1:0] sync_second;
      logic [ByteW-1:0] chunk_command;
      logic [ByteW-1:0] foot_marker;
      logic [ByteW-1:0] end_command;
   } cpfc_cfg_type;

   // One queued item, already classified by the front.
   typedef struct packed {
      cpfc_op_type      opcode;
      logic             first_byte;
      logic             last_byte;
      logic [ByteW-1:0] data_byte;
      logic [31:0]      chunk_offset;
      logic [15:0]      chunk_size;
      logic [ByteW-1:0] data_crc;
   } cpfc_entry_type;

   // CRC8, poly 0x07, MSB first.
   function automatic logic [ByteW-1:0] crc8_byte(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
      logic [ByteW-1:0] c;
      c = crc ^ b;
      for (int i = 0; i < ByteW; i++) begin
         if ((c & CRC_MSB) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/core/cpfc_front.sv
// Front: accepts items, keeps the running payload CRC, builds queue entries.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_front
   import cpfc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_opcode,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic [31:0]      req_chunk_offset,
   input  wire logic [15:0]      req_chunk_size,
   input  wire logic             req_first_byte,
   input  wire logic             req_last_byte,
   input  wire logic             queue_full,
   output logic                  push,
   output cpfc_entry_type        push_entry
);

   logic [ByteW-1:0] data_crc_ff;
   logic [ByteW-1:0] data_crc_in;
   logic [ByteW-1:0] crc_base;
   logic [ByteW-1:0] crc_new;
   cpfc_op_type      op;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign op        = cpfc_op_type'(req_opcode);

   // A first byte restarts the payload CRC.
   assign crc_base = req_first_byte ? '0 : data_crc_ff;
   assign crc_new  = crc8_byte(crc_base, req_data_byte);

   always_comb begin
      data_crc_in = data_crc_ff;
      if (push && op == OP_DATA) begin
         data_crc_in = req_last_byte ? '0 : crc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_crc_ff <= '0;
      end else begin
         data_crc_ff <= data_crc_in;
      end
   end

   always_comb begin
      push_entry.opcode       = op;
      push_entry.first_byte   = req_first_byte;
      push_entry.last_byte    = req_last_byte;
      push_entry.data_byte    = req_data_byte;
      push_entry.chunk_offset = req_chunk_offset;
      push_entry.chunk_size   = req_chunk_size;
      push_entry.data_crc     = crc_new;
   end

endmodule

`default_nettype wire

### rtl/core/cpfc_queue.sv
// Queue: small FIFO of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_queue
   import cpfc_pkg::*;
#(
   parameter int Depth = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire cpfc_entry_type push_entry,
   input  wire logic           pop,
   output cpfc_entry_type      head_entry,
   output logic                not_empty,
   output logic                full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cpfc_entry_type    entries_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign not_empty  = count_ff != '0;
   assign full       = count_ff == CntW'(Depth);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> count_ff == CntW'(Depth))
      else $error("queue lost an entry while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/core/cpfc_back.sv
// Back: byte sequencer that expands queued items into frame bytes.
`timescale 1ns / 1ps
`default_nettype none

module cpfc_back
   import cpfc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cpfc_cfg_type    cfg,
   input  wire cpfc_entry_type  head_entry,
   input  wire logic            head_valid,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_frame_end,
   output logic                 rsp_last_of_item
);

   logic             started_ff, started_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [ByteW-1:0] hdr_crc_ff, hdr_crc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0] rsp_byte_ff;
   logic             rsp_frame_end_ff;
   logic             rsp_last_ff;

   logic             advance;
   logic             is_end;
   logic [PosW-1:0]  start_pos;
   logic [PosW-1:0]  end_pos;
   logic [PosW-1:0]  cur_pos;
   logic [ByteW-1:0] cur_byte;
   logic             cur_frame_end;
   logic             cur_last;
   logic             cur_is_hdr;

   assign is_end    = head_entry.opcode == OP_END;
   assign start_pos = (is_end || head_entry.first_byte) ? POS_SYNC_FIRST : POS_DATA;
   assign end_pos   = is_end ? POS_END_CRC
                    : (head_entry.last_byte ? POS_TERM : POS_DATA);
   assign cur_pos   = started_ff ? pos_ff : start_pos;
   assign cur_last  = cur_pos == end_pos;

   // Output register can take a byte when empty or draining.
   assign advance = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = advance && cur_last;

   always_comb begin
      cur_byte      = '0;
      cur_frame_end = 1'b0;
      cur_is_hdr    = 1'b0;
      if (is_end) begin
         unique case (cur_pos)
            POS_SYNC_FIRST: begin
               cur_byte   = cfg.sync_first;
               cur_is_hdr = 1'b1;
            end
            POS_SYNC_SECOND: begin
               cur_byte   = cfg.sync_second;
               cur_is_hdr = 1'b1;
            end
            POS_COMMAND: begin
               cur_byte   = cfg.end_command;
               cur_is_hdr = 1'b1;
            end
            POS_END_CRC: begin
               cur_byte      = hdr_crc_ff;
               cur_frame_end = 1'b1;
            end
            default: cur_byte = '0;
         endcase
      end else begin
         unique case (cur_pos)
            POS_SYNC_FIRST:  begin cur_byte = cfg.sync_first;   cur_is_hdr = 1'b1; end
            POS_SYNC_SECOND: begin cur_byte = cfg.sync_second;  cur_is_hdr = 1'b1; end
            POS_COMMAND:     begin cur_byte = cfg.chunk_command; cur_is_hdr = 1'b1; end
            POS_OFFSET_0: begin
               cur_byte   = head_entry.chunk_offset[7:0];
               cur_is_hdr = 1'b1;
            end
            POS_OFFSET_1: begin
               cur_byte   = head_entry.chunk_offset[15:8];
               cur_is_hdr = 1'b1;
            end
            POS_OFFSET_2: begin
               cur_byte   = head_entry.chunk_offset[23:16];
               cur_is_hdr = 1'b1;
            end
            POS_OFFSET_3: begin
               cur_byte   = head_entry.chunk_offset[31:24];
               cur_is_hdr = 1'b1;
            end
            POS_SIZE_0: begin
               cur_byte   = head_entry.chunk_size[7:0];
               cur_is_hdr = 1'b1;
            end
            POS_SIZE_1: begin
               cur_byte   = head_entry.chunk_size[15:8];
               cur_is_hdr = 1'b1;
            end
            POS_FOOT:     begin cur_byte = cfg.foot_marker; cur_is_hdr = 1'b1; end
            POS_HDR_CRC:  cur_byte = hdr_crc_ff;
            POS_DATA:     cur_byte = head_entry.data_byte;
            POS_DATA_CRC: cur_byte = head_entry.data_crc;
            POS_TERM: begin
               cur_byte      = TERMINATOR;
               cur_frame_end = 1'b1;
            end
            default: cur_byte = '0;
         endcase
      end
   end

   // Header CRC is folded one byte per emitted header byte.
   always_comb begin
      started_in   = started_ff;
      pos_in       = pos_ff;
      hdr_crc_in   = hdr_crc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         started_in   = !cur_last;
         pos_in       = cur_pos + 1'b1;
         if (cur_is_hdr) begin
            hdr_crc_in = crc8_byte((cur_pos == POS_SYNC_FIRST) ? '0 : hdr_crc_ff,
                                   cur_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_crc_ff <= hdr_crc_in;
      if (advance) begin
         rsp_byte_ff      <= cur_byte;
         rsp_frame_end_ff <= cur_frame_end;
         rsp_last_ff      <= cur_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;
   assign rsp_last_of_item = rsp_last_ff;

`ifndef SYNTH
   a_frame_end_closes_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_end_ff |-> rsp_last_ff)
      else $error("frame end before last byte of item");
   a_started_has_head: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> head_valid)
      else $error("sequencer mid-item with empty queue");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> pos_ff <= POS_TERM)
      else $error("sequencer position out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/chunk_packet_framer_crc8_unit.sv
// Top level: chunk packet framer with CRC8, config registers and front/back pipes.
`timescale 1ns / 1ps
`default_nettype none

// Turns a stream of payload items into framed serial bytes, one byte per
// rsp item. A data item that is neither first nor last gives one byte and
// the block sustains one such item per cycle unless stalled. A first byte
// adds the 11-byte chunk header (sync, sync, command, offset LE, size LE,
// foot, header CRC8), a last byte adds the data CRC8 and 0xFF, and an end
// request gives four bytes (sync, sync, end command, CRC8). A single output
// register gives one byte per cycle unless stalled; an item makes 1 to 14
// bytes. A queue of QueueDepth items lets req keep flowing while header
// bursts drain. CRC8 is poly 0x07, init 0, MSB first. The five 8-bit marker
// registers are written through the csr port (index 0..4, others ignored)
// and must only change while the block is idle; csr_ready is always high.
module chunk_packet_framer_crc8_unit
   import cpfc_pkg::*;
#(
   parameter int QueueDepth = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   // items in
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [31:0] req_chunk_offset,
   input  wire logic [15:0] req_chunk_size,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   // bytes out
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic             rsp_last_of_item
);

   cpfc_cfg_type   cfg_ff, cfg_in;
   cpfc_entry_type push_entry;
   cpfc_entry_type head_entry;
   logic           push;
   logic           pop;
   logic           head_valid;
   logic           queue_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SYNC_FIRST:    cfg_in.sync_first    = csr_data;
            REG_SYNC_SECOND:   cfg_in.sync_second   = csr_data;
            REG_CHUNK_COMMAND: cfg_in.chunk_command = csr_data;
            REG_FOOT_MARKER:   cfg_in.foot_marker   = csr_data;
            REG_END_COMMAND:   cfg_in.end_command   = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, classify, fold payload CRC
   cpfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_chunk_offset (req_chunk_offset),
      .req_chunk_size   (req_chunk_size),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   cpfc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (head_valid),
      .full       (queue_full)
   );

   // back: one frame byte per cycle into the output register unless stalled
   cpfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .head_entry       (head_entry),
      .head_valid       (head_valid),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

`default_nettype wire
